// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the record queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define BTLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle
`define BTLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// BER-TLV parser package
// Shared constants, codes and record types of the stream parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int NestDepth = 8;
  localparam int DepthW    = 4;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_TAG2  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LENX  = 3'd3,
    PH_VALUE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_VAL = 2'd1,
    KIND_OK  = 2'd2,
    KIND_ERR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_BAD_TAG = 3'd1,
    ERR_TRUNC   = 3'd2,
    ERR_LEN     = 3'd3,
    ERR_OVERRUN = 3'd4,
    ERR_DEEP    = 3'd5
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        tag;
    logic [15:0]        vlen;
    logic               cons;
    logic [DepthW-1:0]  depth;
    logic [7:0]         vbyte;
    logic [15:0]        voff;
    err_e               err;
  } res_t;

  // At most one record per byte: an optional primary result and an optional end mark
  typedef struct packed {
    logic prim_v;
    logic ok_v;
    res_t res;
  } rec_t;

endpackage

// ===== hdl/ber_tlv_stream_parser_unit.sv =====
// A byte's results are registered in the record queue and offered from it.
// Throughput: one byte per cycle while the queue is not full; a byte with
// two results needs two output transfers; a four-record queue absorbs this.
// Reset: asynchronous, active low; parse state, queue and register clear,
// the template end stack is written before it is read.
// ----------------------------------------------------------------------------
// BER-TLV stream parser top level
// Parser front end, record queue and output back end.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tag[15:0], value_length[31:16], constructed[32], depth[36:33],
  // value_byte[44:37], value_offset[60:45], error_code[63:61]
  output logic [63:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o
);

  logic           cfg_hdr_q;
  logic           full;
  logic           fire;
  logic           push;
  logic           pop;
  logic           q_valid;
  btlv_pkg::rec_t push_rec;
  btlv_pkg::rec_t head;
  btlv_pkg::res_t res;

  // Hold the header mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_hdr_q <= 1'b0;
    end else if (cfg_we_i) begin
      cfg_hdr_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !full;
  assign fire            = s_axis_tvalid_i && !full;

  btlv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_hdr_i (cfg_hdr_q),
    .fire_i    (fire),
    .data_i    (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .push_o    (push),
    .rec_o     (push_rec)
  );

  btlv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .full_o     (full),
    .valid_o    (q_valid),
    .head_o     (head)
  );

  btlv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .rec_i     (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (res),
    .m_last_o  (m_axis_tlast_o)
  );

  // Pack the result fields
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tdata_o = {res.err, res.voff, res.vbyte, res.depth, res.cons,
                           res.vlen, res.tag};

endmodule

// ===== hdl/btlv_front.sv =====
// ----------------------------------------------------------------------------
// BER-TLV parser front end
// Parses one byte per cycle while fire_i accepts it, and builds the result record for that byte.
// ----------------------------------------------------------------------------
module btlv_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_hdr_i,
  input  logic             fire_i,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  output logic             push_o,
  output btlv_pkg::rec_t   rec_o
);

  btlv_pkg::phase_e           phase_q, phase_d;
  logic [15:0]                pos_q, pos_d;
  logic [15:0]                tag_q, tag_d;
  logic [15:0]                len_q, len_d;
  logic [1:0]                 lleft_q, lleft_d;
  logic [15:0]                vleft_q, vleft_d;
  logic [btlv_pkg::DepthW-1:0] depth_q, depth_d;
  logic                       err_q, err_d;
  logic [15:0]                stack_q [btlv_pkg::NestDepth];

  logic                       push_stk;
  logic [15:0]                end_pos;

  // Parse the byte and derive next state and the record
  always_comb begin
    logic [15:0]                 pos;
    logic [btlv_pkg::DepthW-2:0] tidx;
    logic [15:0]                 top;
    logic                        ends;
    logic                        fail;
    btlv_pkg::err_e              code;
    logic                        hdr_done;
    logic [16:0]                 end17;
    logic [16:0]                 limit;
    logic                        cons;
    logic [btlv_pkg::DepthW-1:0] dn;
    logic [btlv_pkg::DepthW-1:0] newd;
    logic                        stop;
    logic [15:0]                 ent;
    logic                        clr;
    btlv_pkg::res_t              prim;
    logic                        prim_v;
    logic                        ok_v;

    phase_d  = phase_q;
    pos_d    = pos_q;
    tag_d    = tag_q;
    len_d    = len_q;
    lleft_d  = lleft_q;
    vleft_d  = vleft_q;
    depth_d  = depth_q;
    err_d    = err_q;
    push_stk = 1'b0;
    fail     = 1'b0;
    code     = btlv_pkg::ERR_NONE;
    hdr_done = 1'b0;
    clr      = 1'b0;
    prim     = '0;
    prim_v   = 1'b0;
    ok_v     = 1'b0;
    pos      = pos_q + 16'd1;
    tidx     = depth_q[btlv_pkg::DepthW-2:0] - 1'b1;
    top      = (depth_q != '0) ? stack_q[tidx] : 16'd0;
    ends     = last_i || ((depth_q != '0) && (top == pos));
    cons     = 1'b0;
    end17    = '0;
    limit    = '0;
    dn       = depth_q;
    newd     = depth_q;
    stop     = 1'b0;
    ent      = '0;
    end_pos  = '0;

    if (err_q) begin
      clr = last_i;
    end else if (pos_q == 16'hFFFF) begin
      fail = 1'b1;
      code = btlv_pkg::ERR_OVERRUN;
    end else begin
      pos_d = pos;
      case (phase_q)
        btlv_pkg::PH_START: begin
          if (data_i != 8'h00 && data_i != 8'hFF) begin
            tag_d   = {8'h00, data_i};
            phase_d = (data_i[4:0] == 5'h1F) ? btlv_pkg::PH_TAG2 : btlv_pkg::PH_LEN1;
            if (ends) begin
              fail = 1'b1;
              code = btlv_pkg::ERR_TRUNC;
            end
          end
        end
        btlv_pkg::PH_TAG2: begin
          if (data_i[7]) begin
            fail = 1'b1;
            code = btlv_pkg::ERR_BAD_TAG;
          end else begin
            tag_d   = {tag_q[7:0], data_i};
            phase_d = btlv_pkg::PH_LEN1;
            if (ends) begin
              fail = 1'b1;
              code = btlv_pkg::ERR_TRUNC;
            end
          end
        end
        btlv_pkg::PH_LEN1: begin
          if (data_i[7]) begin
            if (data_i[6:0] > 7'd2) begin
              fail = 1'b1;
              code = btlv_pkg::ERR_LEN;
            end else begin
              len_d   = 16'd0;
              lleft_d = data_i[1:0];
              if (data_i[1:0] == 2'd0) begin
                hdr_done = 1'b1;
              end else begin
                phase_d = btlv_pkg::PH_LENX;
                if (ends) begin
                  fail = 1'b1;
                  code = btlv_pkg::ERR_TRUNC;
                end
              end
            end
          end else begin
            len_d    = {8'h00, data_i};
            hdr_done = 1'b1;
          end
        end
        btlv_pkg::PH_LENX: begin
          len_d   = {len_q[7:0], data_i};
          lleft_d = lleft_q - 2'd1;
          if (lleft_d == 2'd0) begin
            hdr_done = 1'b1;
          end else if (ends) begin
            fail = 1'b1;
            code = btlv_pkg::ERR_TRUNC;
          end
        end
        default: begin
          prim_v      = 1'b1;
          prim.kind   = btlv_pkg::KIND_VAL;
          prim.tag    = tag_q;
          prim.vlen   = len_q;
          prim.depth  = depth_q;
          prim.vbyte  = data_i;
          prim.voff   = len_q - vleft_q;
          vleft_d     = vleft_q - 16'd1;
          if (vleft_d == 16'd0) begin
            phase_d = btlv_pkg::PH_START;
          end
        end
      endcase

      // Check the object end and open a template or a value
      if (hdr_done && !fail) begin
        end17   = {1'b0, pos} + {1'b0, len_d};
        end_pos = end17[15:0];
        limit   = (depth_q != '0) ? {1'b0, top} : 17'h0FFFF;
        cons    = (tag_d[15:8] != 8'h00) ? tag_d[13] : tag_d[5];
        if (end17 > limit) begin
          fail = 1'b1;
          code = btlv_pkg::ERR_OVERRUN;
        end else if (cons) begin
          if (depth_q >= btlv_pkg::DepthW'(btlv_pkg::NestDepth)) begin
            fail = 1'b1;
            code = btlv_pkg::ERR_DEEP;
          end else begin
            if (cfg_hdr_i) begin
              prim_v     = 1'b1;
              prim.kind  = btlv_pkg::KIND_HDR;
              prim.tag   = tag_d;
              prim.vlen  = len_d;
              prim.cons  = 1'b1;
              prim.depth = depth_q;
            end
            push_stk = 1'b1;
            phase_d  = btlv_pkg::PH_START;
          end
        end else begin
          prim_v     = 1'b1;
          prim.kind  = btlv_pkg::KIND_HDR;
          prim.tag   = tag_d;
          prim.vlen  = len_d;
          prim.depth = depth_q;
          vleft_d    = len_d;
          phase_d    = (len_d != 16'd0) ? btlv_pkg::PH_VALUE : btlv_pkg::PH_START;
        end
      end

      // Close every template that ends at this byte
      if (!fail) begin
        dn   = depth_q + btlv_pkg::DepthW'(push_stk);
        newd = dn;
        if (phase_d == btlv_pkg::PH_START) begin
          for (int i = btlv_pkg::NestDepth - 1; i >= 0; i--) begin
            ent = (push_stk && depth_q == btlv_pkg::DepthW'(i)) ? end_pos : stack_q[i];
            if ((btlv_pkg::DepthW'(i) < dn) && !stop) begin
              if (ent == pos) begin
                newd = btlv_pkg::DepthW'(i);
              end else begin
                stop = 1'b1;
              end
            end
          end
        end
        depth_d = newd;
        if (last_i) begin
          if (phase_d != btlv_pkg::PH_START || newd != '0) begin
            fail = 1'b1;
            code = btlv_pkg::ERR_OVERRUN;
          end else begin
            ok_v = 1'b1;
            clr  = 1'b1;
          end
        end
      end
    end

    // Replace everything by the error result on a failure
    if (fail) begin
      prim_v    = 1'b1;
      ok_v      = 1'b0;
      prim      = '0;
      prim.kind = btlv_pkg::KIND_ERR;
      prim.err  = code;
      push_stk  = 1'b0;
      if (last_i) begin
        clr = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end

    if (clr) begin
      phase_d = btlv_pkg::PH_START;
      pos_d   = '0;
      tag_d   = '0;
      len_d   = '0;
      lleft_d = '0;
      vleft_d = '0;
      depth_d = '0;
      err_d   = 1'b0;
    end

    rec_o.prim_v = prim_v;
    rec_o.ok_v   = ok_v;
    rec_o.res    = prim;
    push_o       = fire_i && (prim_v || ok_v);
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= btlv_pkg::PH_START;
      pos_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      lleft_q <= '0;
      vleft_q <= '0;
      depth_q <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      lleft_q <= lleft_d;
      vleft_q <= vleft_d;
      depth_q <= depth_d;
      err_q   <= err_d;
    end
  end

  // Push template end positions
  always_ff @(posedge clk_i) begin
    if (fire_i && push_stk) begin
      stack_q[depth_q[btlv_pkg::DepthW-2:0]] <= end_pos;
    end
  end

endmodule

// ===== hdl/btlv_fifo.sv =====
// ----------------------------------------------------------------------------
// BER-TLV record queue
// Short queue of result records between the parser and the output side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btlv_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  btlv_pkg::rec_t push_rec_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output btlv_pkg::rec_t head_o
);

  btlv_pkg::rec_t                mem_q [btlv_pkg::FifoDepth];
  logic [btlv_pkg::FifoAw-1:0]   wptr_q, rptr_q;
  logic [btlv_pkg::FifoAw:0]     cnt_q;

  assign full_o  = (cnt_q == (btlv_pkg::FifoAw+1)'(btlv_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  // Store records
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_rec_i;
    end
  end

  // Move pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (btlv_pkg::FifoAw+1)'(push_i) - (btlv_pkg::FifoAw+1)'(pop_i);
    end
  end

  `BTLV_ASSERT(a_no_push_full, !(push_i && full_o), "push into full queue")
  `BTLV_ASSERT(a_no_pop_empty, !(pop_i && !valid_o), "pop from empty queue")
  `BTLV_ASSERT_NEXT(a_cnt_hold, (push_i == pop_i), $stable(cnt_q), "count moved without net change")

endmodule

// ===== hdl/btlv_back.sv =====
// ----------------------------------------------------------------------------
// BER-TLV parser back end
// Splits each record into one or two result transfers on the output stream.
// ----------------------------------------------------------------------------
module btlv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  btlv_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output btlv_pkg::res_t m_res_o,
  output logic           m_last_o
);

  logic sub_q, sub_d;
  logic two;
  logic emit_ok;
  logic fire;

  assign two     = rec_i.prim_v && rec_i.ok_v;
  assign emit_ok = rec_i.ok_v && (!rec_i.prim_v || sub_q);
  assign fire    = valid_i && m_ready_i;

  // Select the result for this transfer
  always_comb begin
    m_res_o = rec_i.res;
    if (emit_ok) begin
      m_res_o      = '0;
      m_res_o.kind = btlv_pkg::KIND_OK;
    end
  end

  assign m_valid_o = valid_i;
  assign m_last_o  = !(two && !sub_q);
  assign pop_o     = fire && m_last_o;
  assign sub_d     = fire ? (two && !sub_q) : sub_q;

  // Track the second half of a two-result record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule
